>>> src/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check prop at every rising edge, reset included.
`define ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> src/bma_pkg.sv
// Constants, codes and header layout of the buddy allocator.
package bma_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int MIN_ORDER_DEF = 5;
  localparam int MIN_REQUEST   = 16;
  localparam int ORD_W         = 5;
  localparam int TOTAL_RESET   = 16;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic CFG_TOTAL_ORDER = 1'b0;
  localparam logic CFG_FIT_MODE    = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             occ;
    logic [ORD_W-1:0] ord;
  } hdr_t;

endpackage

>>> src/buddy_memory_allocator_unit.sv
// Buddy allocator with its header table held in one synchronous memory.
//
//   channel | direction | handshake          | payload
//   in      | to unit   | in_valid/in_stall  | func, req_bytes, free_address
//   out     | from unit | out_valid/out_stall| address, block_order, status
//   cfg     | to unit   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Reset and a total_order write sweep the table.
// Allocate: read, check each scanned header; write per split and at the finish.
// Free: read and check the header; per merge read, check, write the pair;
// a buddy that does not merge is read and checked. S_DONE then loads the result.
// A stalled result holds in the output register while the next item is taken.
`include "assert_macros.svh"

module buddy_memory_allocator_unit
  import bma_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int MIN_ORDER = MIN_ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [15:0]      req_bytes,
  input  logic [15:0]      free_address,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      address,
  output logic [ORD_W-1:0] block_order,
  output logic [1:0]       status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [4:0]       cfg_data
);

  localparam int SLOT_W = MAX_ORDER - MIN_ORDER;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int SZ_W   = (MAX_ORDER + 2 > 18) ? MAX_ORDER + 2 : 18;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_INIT  = 12'b000000000010,
    S_IDLE  = 12'b000000000100,
    S_A_RD  = 12'b000000001000,
    S_A_CHK = 12'b000000010000,
    S_SPLIT = 12'b000000100000,
    S_F_RD  = 12'b000001000000,
    S_F_CHK = 12'b000010000000,
    S_M_RD  = 12'b000100000000,
    S_M_CHK = 12'b001000000000,
    S_M_WR  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  hdr_t mem [SLOTS];
  hdr_t rd_data;

  logic [ORD_W-1:0]  total_order;
  logic [1:0]        fit_mode;
  logic [SLOT_W:0]   scan_i;
  logic [SLOT_W-1:0] best, slot, clr;
  logic [ORD_W-1:0]  best_o, ord;
  logic              found;
  logic [16:0]       need;
  logic [15:0]       res_addr;
  logic [ORD_W-1:0]  res_ord;
  logic [1:0]        res_status;

  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              we;
  hdr_t              wr_data;

  logic [ORD_W-1:0]  eo;
  logic              take, first, scan_end, split_ok, merge_ok, f_bad, cfg_wr;
  logic [SLOT_W:0]   next_i, slots;
  logic [SLOT_W-1:0] bslot, f_slot, split_slot;
  logic [15:0]       f_off;
  logic [SZ_W-1:0]   pool, need_w;
  logic [MAX_ORDER:0] alloc_addr;

  function automatic logic fits(input logic [ORD_W-1:0] o, input logic [SZ_W-1:0] n);
    return (SZ_W'(1) << o) >= n;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    eo = rd_data.ord;
    if (eo < ORD_W'(MIN_ORDER)) eo = ORD_W'(MIN_ORDER);
    if (eo > total_order) eo = total_order;
  end

  assign need_w   = SZ_W'(need);
  assign first    = !(fit_mode inside {FIT_BEST, FIT_WORST});
  assign take     = rd_data.valid && !rd_data.occ && fits(eo, need_w) &&
                    (!found || (fit_mode == FIT_BEST && eo < best_o) ||
                     (fit_mode == FIT_WORST && eo > best_o));
  assign next_i   = scan_i + (rd_data.valid ? ((SLOT_W+1)'(1) << (eo - ORD_W'(MIN_ORDER)))
                                            : (SLOT_W+1)'(1));
  assign slots    = (SLOT_W+1)'(1) << (total_order - ORD_W'(MIN_ORDER));
  assign scan_end = next_i >= slots;
  assign split_ok = best_o > ORD_W'(MIN_ORDER) && fits(best_o - ORD_W'(1), need_w);
  assign split_slot = best + (SLOT_W'(1) << (best_o - ORD_W'(1) - ORD_W'(MIN_ORDER)));
  assign bslot    = slot ^ (SLOT_W'(1) << (ord - ORD_W'(MIN_ORDER)));
  assign merge_ok = rd_data.valid && !rd_data.occ && rd_data.ord == ord;
  assign pool     = SZ_W'(1) << total_order;
  assign f_off    = free_address - 16'd1;
  assign f_bad    = free_address == 16'd0 || SZ_W'(f_off) >= pool ||
                    f_off[MIN_ORDER-1:0] != '0;
  assign f_slot   = SLOT_W'(SZ_W'(f_off) >> MIN_ORDER);
  assign alloc_addr = {1'b0, best, {MIN_ORDER{1'b0}}} + (MAX_ORDER+1)'(1);

  always_comb begin
    state_next = state;
    rd_addr    = scan_i[SLOT_W-1:0];
    we         = 1'b0;
    wr_addr    = slot;
    wr_data    = '0;
    case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr;
        if (clr == SLOT_W'(SLOTS - 1)) state_next = S_INIT;
      end
      S_INIT: begin
        we         = 1'b1;
        wr_addr    = '0;
        wr_data    = '{valid: 1'b1, occ: 1'b0, ord: total_order};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (func == FN_ALLOC) state_next = S_A_RD;
          else if (f_bad) state_next = S_DONE;
          else state_next = S_F_RD;
        end
      end
      S_A_RD: state_next = S_A_CHK;
      S_A_CHK: begin
        if ((take && first) || scan_end) begin
          state_next = (found || take) ? S_SPLIT : S_DONE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (split_ok) begin
          wr_addr = split_slot;
          wr_data = '{valid: 1'b1, occ: 1'b0, ord: best_o - ORD_W'(1)};
        end else begin
          wr_addr    = best;
          wr_data    = '{valid: 1'b1, occ: 1'b1, ord: best_o};
          state_next = S_DONE;
        end
      end
      S_F_RD: begin
        rd_addr    = slot;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (!(rd_data.valid && rd_data.occ)) begin
          state_next = S_DONE;
        end else begin
          we         = 1'b1;
          wr_data    = '{valid: 1'b1, occ: 1'b0, ord: eo};
          state_next = (eo < total_order) ? S_M_RD : S_DONE;
        end
      end
      S_M_RD: begin
        rd_addr    = bslot;
        state_next = S_M_CHK;
      end
      S_M_CHK: begin
        if (merge_ok) begin
          we         = 1'b1;
          wr_addr    = (bslot < slot) ? slot : bslot;
          state_next = S_M_WR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_M_WR: begin
        we         = 1'b1;
        wr_data    = '{valid: 1'b1, occ: 1'b0, ord: ord};
        state_next = (ord < total_order) ? S_M_RD : S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      total_order <= ORD_W'(TOTAL_RESET > MAX_ORDER ? MAX_ORDER : TOTAL_RESET);
      fit_mode    <= FIT_FIRST;
      out_valid   <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (cfg_wr && cfg_index == CFG_TOTAL_ORDER) begin
        state <= S_CLEAR;
        clr   <= '0;
      end else begin
        state <= state_next;
        if (state == S_CLEAR) clr <= clr + SLOT_W'(1);
      end
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            need   <= 17'(req_bytes < 16'(MIN_REQUEST) ? 16'(MIN_REQUEST)
                                                       : req_bytes) + 17'd1;
            scan_i <= '0;
            found  <= 1'b0;
            slot   <= f_slot;
            res_addr   <= '0;
            res_ord    <= '0;
            res_status <= ST_BADFREE;
          end
        end
        S_A_CHK: begin
          if (take) begin
            best   <= scan_i[SLOT_W-1:0];
            best_o <= eo;
            found  <= 1'b1;
          end
          scan_i <= next_i;
          if (!(found || take) && scan_end) res_status <= ST_NOSPACE;
        end
        S_SPLIT: begin
          if (split_ok) begin
            best_o <= best_o - ORD_W'(1);
          end else begin
            res_addr   <= 16'(alloc_addr);
            res_ord    <= best_o;
            res_status <= ST_OK;
          end
        end
        S_F_CHK: begin
          ord <= eo;
          if (rd_data.valid && rd_data.occ) begin
            res_ord    <= eo;
            res_status <= ST_OK;
          end
        end
        S_M_CHK: begin
          if (merge_ok) begin
            if (bslot < slot) slot <= bslot;
            ord     <= ord + ORD_W'(1);
            res_ord <= ord + ORD_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            address     <= res_addr;
            block_order <= res_ord;
            status      <= res_status;
          end
        end
        default: ;
      endcase
      if (cfg_wr) begin
        if (cfg_index == CFG_TOTAL_ORDER) begin
          total_order <= (cfg_data < ORD_W'(MIN_ORDER)) ? ORD_W'(MIN_ORDER) :
                         (cfg_data > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : cfg_data;
        end else if (cfg_index == CFG_FIT_MODE) begin
          fit_mode <= cfg_data[1:0];
        end
      end
    end
  end

  `ASSERT_CLK(a_state_onehot, clk, rst, $onehot(state))
  `ASSERT_CLK(a_fail_zero, clk, rst,
    (out_valid && status != ST_OK) |-> (address == 16'd0 && block_order == '0))
  `ASSERT_CLK(a_result_load, clk, rst,
    (state == S_DONE && !cfg_wr && (!out_valid || !out_stall)) |=> (out_valid && state == S_IDLE))
  `ASSERT_CLK(a_write_states, clk, rst,
    we |-> (state == S_CLEAR || state == S_INIT || state == S_SPLIT ||
            state == S_F_CHK || state == S_M_CHK || state == S_M_WR))

endmodule
